// ===== rtl/track_hit_geometry_cut_assert.svh =====
// Assertion macros for the track hit geometry cut block.
// Depends on nothing; taken in by the top level.
`ifndef TRACK_HIT_GEOMETRY_CUT_ASSERT_SVH
`define TRACK_HIT_GEOMETRY_CUT_ASSERT_SVH

// implication in the same cycle
`define THGC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequence delayed by the dly argument
`define THGC_ASSERT_LAT(lbl, clk_i, rstn_i, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/thgc_pkg.sv =====
// Shared types and constants for the track hit geometry cut block.
// Depends on nothing.
`default_nettype none

package thgc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TOWER_GRID_DEF = 4;

    localparam int LIM_W   = 17;
    localparam int PLIM_W  = 15;
    localparam int PITCH_W = 14;
    localparam int SIN_Q   = 16;
    localparam int KW      = 5;
    localparam int CTR_W   = KW + PITCH_W + 1;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [5:0] FACES_TOP_BOTTOM = 6'h03;

    localparam logic [LIM_W-1:0]   RST_MAX_ORTH = 17'd16384;
    localparam logic [LIM_W-1:0]   RST_MAX_LONG = 17'd49152;
    localparam logic [PLIM_W-1:0]  RST_POS_LIM  = 15'd2128;
    localparam logic [PITCH_W-1:0] RST_PITCH    = 14'd5992;

    typedef enum logic [2:0] {
        REG_FACES_EN  = 3'd0,
        REG_ANGLE_EN  = 3'd1,
        REG_POS_EN    = 3'd2,
        REG_MAX_ORTH  = 3'd3,
        REG_MAX_LONG  = 3'd4,
        REG_POS_LIMIT = 3'd5,
        REG_PITCH     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        FAIL_NONE  = 2'd0,
        FAIL_FACES = 2'd1,
        FAIL_ANGLE = 2'd2,
        FAIL_POS   = 2'd3
    } fail_t;

    typedef struct packed {
        logic                faces_en;
        logic                angle_en;
        logic                pos_en;
        logic [LIM_W-1:0]    max_orth;
        logic [LIM_W-1:0]    max_long;
        logic [PLIM_W-1:0]   pos_limit;
        logic [PITCH_W-1:0]  pitch;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic ydir;
        logic faces_fail;
        logic pos_fail;
    } flags_t;

endpackage

`default_nettype wire

// ===== rtl/thgc_regs.sv =====
// APB-style configuration registers of the track hit geometry cut block.
// Depends on thgc_pkg.
`default_nettype none

module thgc_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [thgc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [thgc_pkg::DATA_W-1:0] pwdata,
    output logic      [thgc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output thgc_pkg::cfg_t                   cfg
);
    import thgc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_FACES_EN:  cfg_next.faces_en  = pwdata[0];
                REG_ANGLE_EN:  cfg_next.angle_en  = pwdata[0];
                REG_POS_EN:    cfg_next.pos_en    = pwdata[0];
                REG_MAX_ORTH:  cfg_next.max_orth  = pwdata[LIM_W-1:0];
                REG_MAX_LONG:  cfg_next.max_long  = pwdata[LIM_W-1:0];
                REG_POS_LIMIT: cfg_next.pos_limit = pwdata[PLIM_W-1:0];
                REG_PITCH:     cfg_next.pitch     = pwdata[PITCH_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.faces_en  <= 1'b1;
            cfg_reg.angle_en  <= 1'b1;
            cfg_reg.pos_en    <= 1'b1;
            cfg_reg.max_orth  <= RST_MAX_ORTH;
            cfg_reg.max_long  <= RST_MAX_LONG;
            cfg_reg.pos_limit <= RST_POS_LIM;
            cfg_reg.pitch     <= RST_PITCH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_FACES_EN:  prdata = DATA_W'(cfg_reg.faces_en);
            REG_ANGLE_EN:  prdata = DATA_W'(cfg_reg.angle_en);
            REG_POS_EN:    prdata = DATA_W'(cfg_reg.pos_en);
            REG_MAX_ORTH:  prdata = DATA_W'(cfg_reg.max_orth);
            REG_MAX_LONG:  prdata = DATA_W'(cfg_reg.max_long);
            REG_POS_LIMIT: prdata = DATA_W'(cfg_reg.pos_limit);
            REG_PITCH:     prdata = DATA_W'(cfg_reg.pitch);
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/thgc_geom.sv =====
// Front stages: path deltas, squared components, face and position cuts.
// Depends on thgc_pkg.
`default_nettype none

module thgc_geom #(
    parameter int COORD_BITS = thgc_pkg::COORD_BITS_DEF,
    parameter int TOWER_GRID = thgc_pkg::TOWER_GRID_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire thgc_pkg::cfg_t                 cfg,
    input  wire logic [5:0]                     crossed_faces,
    input  wire logic                           xtal_dir,
    input  wire logic [1:0]                     tower_col,
    input  wire logic [1:0]                     tower_row,
    input  wire logic signed [COORD_BITS-1:0]   entry_x,
    input  wire logic signed [COORD_BITS-1:0]   entry_y,
    input  wire logic signed [COORD_BITS-1:0]   entry_z,
    input  wire logic signed [COORD_BITS-1:0]   exit_x,
    input  wire logic signed [COORD_BITS-1:0]   exit_y,
    input  wire logic signed [COORD_BITS-1:0]   exit_z,
    output thgc_pkg::flags_t                    flags,
    output logic [2*COORD_BITS+1:0]             sq_x,
    output logic [2*COORD_BITS+1:0]             sq_y,
    output logic [2*COORD_BITS+1:0]             sq_z
);
    import thgc_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * DW;
    localparam int PW  = ((DW > CTR_W) ? DW : CTR_W) + 1;
    localparam int OFS = 2 * (TOWER_GRID / 2) - 1;

    flags_t                   s1_flags_reg, s1_flags_next;
    logic signed [DW-1:0]     s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [DW-1:0]     s1_a2_reg, s1_b2_reg;
    logic signed [CTR_W-1:0]  s1_ctr_reg, ctr_next;
    flags_t                   s2_flags_reg, s2_flags_next;
    logic [SQW-1:0]           s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;

    logic [1:0]               n;
    logic signed [KW-1:0]     k;
    logic [DW-1:0]            mx, my, mz;
    logic signed [PW-1:0]     pda, pdb;
    logic [PW-1:0]            pma, pmb, lim2;

    // stage 1: deltas, selected coordinates doubled, doubled crystal centre
    assign n = xtal_dir ? tower_row : tower_col;
    assign k = $signed({2'b00, n, 1'b0}) - $signed(KW'(OFS));
    assign ctr_next = $signed({{(CTR_W-KW){k[KW-1]}}, k})
                    * $signed({{(CTR_W-PITCH_W){1'b0}}, cfg.pitch});

    always_comb
    begin
        s1_flags_next.valid      = in_valid;
        s1_flags_next.ydir       = xtal_dir;
        s1_flags_next.faces_fail = cfg.faces_en && (crossed_faces != FACES_TOP_BOTTOM);
        s1_flags_next.pos_fail   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_flags_reg <= '0;
            s2_flags_reg <= '0;
        end
        else
        begin
            s1_flags_reg <= s1_flags_next;
            s2_flags_reg <= s2_flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg  <= $signed({exit_x[COORD_BITS-1], exit_x})
                    - $signed({entry_x[COORD_BITS-1], entry_x});
        s1_dy_reg  <= $signed({exit_y[COORD_BITS-1], exit_y})
                    - $signed({entry_y[COORD_BITS-1], entry_y});
        s1_dz_reg  <= $signed({exit_z[COORD_BITS-1], exit_z})
                    - $signed({entry_z[COORD_BITS-1], entry_z});
        s1_a2_reg  <= $signed({(xtal_dir ? entry_y : entry_x), 1'b0});
        s1_b2_reg  <= $signed({(xtal_dir ? exit_y : exit_x), 1'b0});
        s1_ctr_reg <= ctr_next;
    end

    // stage 2: magnitudes squared, distance from centre in 1/32 mm
    assign mx = s1_dx_reg[DW-1] ? (~s1_dx_reg + 1'b1) : s1_dx_reg;
    assign my = s1_dy_reg[DW-1] ? (~s1_dy_reg + 1'b1) : s1_dy_reg;
    assign mz = s1_dz_reg[DW-1] ? (~s1_dz_reg + 1'b1) : s1_dz_reg;

    assign pda = $signed({{(PW-DW){s1_a2_reg[DW-1]}}, s1_a2_reg})
               - $signed({{(PW-CTR_W){s1_ctr_reg[CTR_W-1]}}, s1_ctr_reg});
    assign pdb = $signed({{(PW-DW){s1_b2_reg[DW-1]}}, s1_b2_reg})
               - $signed({{(PW-CTR_W){s1_ctr_reg[CTR_W-1]}}, s1_ctr_reg});
    assign pma  = pda[PW-1] ? (~pda + 1'b1) : pda;
    assign pmb  = pdb[PW-1] ? (~pdb + 1'b1) : pdb;
    assign lim2 = {{(PW-PLIM_W-1){1'b0}}, cfg.pos_limit, 1'b0};

    always_comb
    begin
        s2_flags_next          = s1_flags_reg;
        s2_flags_next.pos_fail = cfg.pos_en && ((pma > lim2) || (pmb > lim2));
    end

    always_ff @(posedge clk)
    begin
        s2_sqx_reg <= mx * mx;
        s2_sqy_reg <= my * my;
        s2_sqz_reg <= mz * mz;
    end

    assign flags = s2_flags_reg;
    assign sq_x  = s2_sqx_reg;
    assign sq_y  = s2_sqy_reg;
    assign sq_z  = s2_sqz_reg;

endmodule

`default_nettype wire

// ===== rtl/thgc_angle.sv =====
// Back stages: squared length, split limit products, angle compare, result.
// Depends on thgc_pkg.
`default_nettype none

module thgc_angle #(
    parameter int COORD_BITS = thgc_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire thgc_pkg::cfg_t            cfg,
    input  wire thgc_pkg::flags_t          flags,
    input  wire logic [2*COORD_BITS+1:0]   sq_x,
    input  wire logic [2*COORD_BITS+1:0]   sq_y,
    input  wire logic [2*COORD_BITS+1:0]   sq_z,
    output logic                           done,
    output logic                           hit_pass,
    output logic [1:0]                     fail_reason
);
    import thgc_pkg::*;

    localparam int MW  = COORD_BITS + 1;
    localparam int SQW = 2 * MW;
    localparam int PPW = LIM_W + MW;
    localparam int RW  = LIM_W + SQW;

    flags_t         s3_flags_reg, s4_flags_reg;
    logic [SQW-1:0] s3_len2_reg, s3_sql_reg, s3_sqo_reg;
    logic [SQW-1:0] s4_sql_reg, s4_sqo_reg;
    logic [PPW-1:0] s4_pl_lo_reg, s4_pl_hi_reg, s4_po_lo_reg, s4_po_hi_reg;
    logic           s5_valid_reg;
    fail_t          s5_reason_reg, reason_next;

    logic [RW-1:0]  lhs_l, lhs_o, rhs_l, rhs_o;
    logic           angle_fail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_flags_reg <= '0;
            s4_flags_reg <= '0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_flags_reg <= flags;
            s4_flags_reg <= s3_flags_reg;
            s5_valid_reg <= s4_flags_reg.valid;
        end
    end

    // stage 3: squared path length, longitudinal and orthogonal terms
    always_ff @(posedge clk)
    begin
        s3_len2_reg <= sq_x + sq_y + sq_z;
        s3_sql_reg  <= flags.ydir ? sq_y : sq_x;
        s3_sqo_reg  <= flags.ydir ? sq_x : sq_y;
    end

    // stage 4: limit times length, in two halves
    always_ff @(posedge clk)
    begin
        s4_pl_lo_reg <= cfg.max_long * s3_len2_reg[MW-1:0];
        s4_pl_hi_reg <= cfg.max_long * s3_len2_reg[SQW-1:MW];
        s4_po_lo_reg <= cfg.max_orth * s3_len2_reg[MW-1:0];
        s4_po_hi_reg <= cfg.max_orth * s3_len2_reg[SQW-1:MW];
        s4_sql_reg   <= s3_sql_reg;
        s4_sqo_reg   <= s3_sqo_reg;
    end

    // stage 5: recombine, compare, pick the first failed cut
    assign rhs_l = {s4_pl_hi_reg, {MW{1'b0}}} + RW'(s4_pl_lo_reg);
    assign rhs_o = {s4_po_hi_reg, {MW{1'b0}}} + RW'(s4_po_lo_reg);
    assign lhs_l = RW'({s4_sql_reg, {SIN_Q{1'b0}}});
    assign lhs_o = RW'({s4_sqo_reg, {SIN_Q{1'b0}}});
    assign angle_fail = cfg.angle_en && ((lhs_l > rhs_l) || (lhs_o > rhs_o));

    always_comb
    begin
        if (s4_flags_reg.faces_fail)
            reason_next = FAIL_FACES;
        else if (angle_fail)
            reason_next = FAIL_ANGLE;
        else if (s4_flags_reg.pos_fail)
            reason_next = FAIL_POS;
        else
            reason_next = FAIL_NONE;
    end

    always_ff @(posedge clk)
    begin
        s5_reason_reg <= reason_next;
    end

    assign done        = s5_valid_reg;
    assign fail_reason = s5_reason_reg;
    assign hit_pass    = (s5_reason_reg == FAIL_NONE);

endmodule

`default_nettype wire

// ===== rtl/track_hit_geometry_cut.sv =====
// Track hit geometry cut: face, angle and position qualification of a hit.
// Five register stages; a result strobes on done once a hit has passed stages s1 to s5.
// One hit accepted every cycle; busy stays low, set by the fully pipelined path.
// The receiver cannot stall; results appear for one cycle only.
// Reset clears every stage valid bit and loads the register reset values.
// Depends on thgc_pkg, thgc_regs, thgc_geom, thgc_angle and the assert header.
`default_nettype none

`include "track_hit_geometry_cut_assert.svh"

module track_hit_geometry_cut #(
    parameter int COORD_BITS = thgc_pkg::COORD_BITS_DEF,
    parameter int TOWER_GRID = thgc_pkg::TOWER_GRID_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [5:0]                   crossed_faces,
    input  wire logic                         xtal_dir,
    input  wire logic [1:0]                   tower_col,
    input  wire logic [1:0]                   tower_row,
    input  wire logic signed [COORD_BITS-1:0] entry_x,
    input  wire logic signed [COORD_BITS-1:0] entry_y,
    input  wire logic signed [COORD_BITS-1:0] entry_z,
    input  wire logic signed [COORD_BITS-1:0] exit_x,
    input  wire logic signed [COORD_BITS-1:0] exit_y,
    input  wire logic signed [COORD_BITS-1:0] exit_z,
    output logic                              done,
    output logic                              hit_pass,
    output logic [1:0]                        fail_reason,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [thgc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [thgc_pkg::DATA_W-1:0]  pwdata,
    output logic      [thgc_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import thgc_pkg::*;

    localparam int LATENCY = 5;

    cfg_t                   cfg;
    flags_t                 flags;
    logic [2*COORD_BITS+1:0] sq_x, sq_y, sq_z;

    assign busy = 1'b0;

    thgc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thgc_geom #(
        .COORD_BITS (COORD_BITS),
        .TOWER_GRID (TOWER_GRID)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .cfg           (cfg),
        .crossed_faces (crossed_faces),
        .xtal_dir      (xtal_dir),
        .tower_col     (tower_col),
        .tower_row     (tower_row),
        .entry_x       (entry_x),
        .entry_y       (entry_y),
        .entry_z       (entry_z),
        .exit_x        (exit_x),
        .exit_y        (exit_y),
        .exit_z        (exit_z),
        .flags         (flags),
        .sq_x          (sq_x),
        .sq_y          (sq_y),
        .sq_z          (sq_z)
    );

    thgc_angle #(
        .COORD_BITS (COORD_BITS)
    ) u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .flags       (flags),
        .sq_x        (sq_x),
        .sq_y        (sq_y),
        .sq_z        (sq_z),
        .done        (done),
        .hit_pass    (hit_pass),
        .fail_reason (fail_reason)
    );

    `THGC_ASSERT_LAT(a_transfer_latency, clk, rst_n, start && !busy, LATENCY, done, "result transfer missing after accepted hit")
    `THGC_ASSERT_IMP(a_pass_matches_reason, clk, rst_n, done, hit_pass == (fail_reason == FAIL_NONE), "pass flag disagrees with fail reason")
    `THGC_ASSERT_IMP(a_no_spurious_result, clk, rst_n, !$past(start && !busy, LATENCY) && $past(rst_n, LATENCY) && $past(rst_n, 1), !done, "result transfer without accepted hit")

endmodule

`default_nettype wire
